// ===== rtl/core/fcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared widths and codes of the filled circle span generator.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsg_pkg;

    // field widths of the stream items
    localparam int CX_W    = 16;   // center column / row, signed
    localparam int RAD_W   = 14;   // radius field
    localparam int MASK_W  = 8;
    localparam int ROW_W   = 12;   // row field of a span
    localparam int SPAN_W  = 17;   // span ends, signed
    localparam int CFG_W   = 13;   // screen size registers
    localparam int WIDE_W  = 18;   // signed working width for cx +/- r

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // largest value a screen size register can hold
    localparam int CFG_MAX = (2 ** CFG_W) - 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    // input item kinds (tuser)
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    typedef logic signed [WIDE_W-1:0] t_wide;

endpackage

`default_nettype wire

// ===== rtl/core/filled_circle_span_generator.sv =====
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Emits the clipped horizontal spans of a filled circle, one row per item.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                   | contents
//  ---------+-----+-----------------------------+--------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | start or next-row item
//  m_axis   | out | m_axis_tvalid/m_axis_tready | span per active next-row item
//  cfg      | in  | i_cfg_valid/o_cfg_ready     | screen width / height writes
//
//  A next-row item: r +/- |dy| is registered at the accepting edge, then the
//  product goes into the root unit, which works out RADIUS_BITS (max 14) root
//  bits; then the done flag is raised and the span is clipped into the output
//  register, which opens the input again. Start and idle next leave it open.
//  Reset (synchronous, active low) clears the circle, idle, screen 320 x 256.
//  A stalled output holds the span; a next span waits and the input is refused.
//
`default_nettype none

module filled_circle_span_generator import fcsg_pkg::*; #(
    parameter int MAX_SCREEN_DIM = 4096,
    parameter int RADIUS_BITS    = 14
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // cfg write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    // input items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // center_x[15:0], center_y[31:16], radius[45:32], pixel_mask[53:46], zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]             s_axis_tuser,
    // result items
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // row[11:0], span_start[28:12], span_end[45:29], mask_out[53:46], zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // span_empty[0]
    output logic [0:0]                  m_axis_tuser,
    // last_row
    output logic                        m_axis_tlast
);

    // effective radius width: the field is only RAD_W bits wide
    localparam int RE = (RADIUS_BITS < RAD_W) ? RADIUS_BITS : RAD_W;
    localparam logic [CFG_W-1:0] DIM_CAP =
        CFG_W'((MAX_SCREEN_DIM > CFG_MAX) ? CFG_MAX : MAX_SCREEN_DIM);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ROOT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // config registers
    logic [CFG_W-1:0] r_scr_w, r_scr_h;
    logic [CFG_W-1:0] w_eff_w, w_eff_h;

    // circle state
    logic signed [CX_W-1:0] r_cx, r_cy;
    logic [RE-1:0]          r_rad;
    logic [MASK_W-1:0]      r_mask;
    logic [CFG_W-1:0]       r_row, r_end_row;
    logic                   r_active;

    // per-span work
    logic [1:0]        r_state, n_state;
    logic [RE:0]       r_sum;        // r + |dy|
    logic [RE-1:0]     r_diff;       // r - |dy|
    logic [2*RE-1:0]   w_prod;       // r*r - dy*dy
    logic [ROW_W-1:0]  r_span_row;
    logic              r_span_last;

    // output register
    logic                     r_out_valid;
    logic [ROW_W-1:0]         r_out_row;
    logic [SPAN_W-1:0]        r_out_x0, r_out_x1;
    logic                     r_out_empty;
    logic [MASK_W-1:0]        r_out_mask;
    logic                     r_out_last;

    // input fields
    logic                     w_cmd;
    logic signed [CX_W-1:0]   w_in_cx, w_in_cy;
    logic [RAD_W-1:0]         w_in_rad;
    logic [MASK_W-1:0]        w_in_mask;
    logic                     w_in_acc;

    // start geometry
    t_wide w_y0, w_y1, w_y0c, w_y1c, w_ylim;
    // row offset
    t_wide w_dy, w_ady;
    // span clipping
    logic [RE-1:0]            w_xx;
    logic                     w_root_done;
    t_wide w_x0, w_x1, w_x0c, w_x1c, w_wmax;
    logic                     w_load_out;

    assign w_cmd     = s_axis_tuser[0];
    assign w_in_cx   = s_axis_tdata[15:0];
    assign w_in_cy   = s_axis_tdata[31:16];
    assign w_in_rad  = s_axis_tdata[45:32];
    assign w_in_mask = s_axis_tdata[53:46];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // oversized screen registers act as the cap
    assign w_eff_w = (r_scr_w > DIM_CAP) ? DIM_CAP : r_scr_w;
    assign w_eff_h = (r_scr_h > DIM_CAP) ? DIM_CAP : r_scr_h;

    // --- start: clip cy-r .. cy+r to the screen rows ---
    always_comb begin
        w_y0   = WIDE_W'(w_in_cy) - t_wide'({{(WIDE_W-RE){1'b0}}, w_in_rad[RE-1:0]});
        w_y1   = WIDE_W'(w_in_cy) + t_wide'({{(WIDE_W-RE){1'b0}}, w_in_rad[RE-1:0]});
        w_ylim = t_wide'({{(WIDE_W-CFG_W){1'b0}}, w_eff_h}) - t_wide'(1);
        w_y0c  = (w_y0 < 0) ? t_wide'(0) : w_y0;
        w_y1c  = (w_y1 > w_ylim) ? w_ylim : w_y1;
    end

    // --- next: |row - cy|, always <= r while a circle is active ---
    always_comb begin
        w_dy  = t_wide'({{(WIDE_W-CFG_W){1'b0}}, r_row}) - WIDE_W'(r_cy);
        w_ady = (w_dy < 0) ? -w_dy : w_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= CFG_W'(320);
            r_scr_h <= CFG_W'(256);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx      <= '0;
            r_cy      <= '0;
            r_rad     <= '0;
            r_mask    <= '0;
            r_row     <= '0;
            r_end_row <= '0;
            r_active  <= 1'b0;
        end else if (w_in_acc) begin
            if (w_cmd == CMD_START) begin
                r_cx      <= w_in_cx;
                r_cy      <= w_in_cy;
                r_rad     <= w_in_rad[RE-1:0];
                r_mask    <= w_in_mask;
                r_row     <= w_y0c[CFG_W-1:0];
                r_end_row <= w_y1c[CFG_W-1:0];
                r_active  <= (w_y0c <= w_y1c);
            end else if (r_active) begin
                if (r_row == r_end_row) begin
                    r_active <= 1'b0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
        end
    end

    // operands of r*r - dy*dy = (r + |dy|) * (r - |dy|)
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_cmd == CMD_NEXT) && r_active) begin
            r_sum       <= {1'b0, r_rad} + (RE+1)'(w_ady[RE-1:0]);
            r_diff      <= r_rad - w_ady[RE-1:0];
            r_span_row  <= r_row[ROW_W-1:0];
            r_span_last <= (r_row == r_end_row);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_acc && (w_cmd == CMD_NEXT) && r_active) n_state = S_MUL;
            S_MUL:  n_state = S_ROOT;
            S_ROOT: if (w_root_done) n_state = S_OUT;
            S_OUT:  if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // product fits 2*RE bits since |dy| <= r
    assign w_prod = (2*RE)'(r_sum) * (2*RE)'(r_diff);

    // product is registered as the radicand inside the root unit
    fcsg_isqrt #(
        .RB (RE)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_MUL),
        .i_radicand (w_prod),
        .o_done     (w_root_done),
        .o_root     (w_xx)
    );

    // --- span ends, clipped to 0 .. width-1 ---
    always_comb begin
        w_x0   = WIDE_W'(r_cx) - t_wide'({{(WIDE_W-RE){1'b0}}, w_xx});
        w_x1   = WIDE_W'(r_cx) + t_wide'({{(WIDE_W-RE){1'b0}}, w_xx});
        w_wmax = t_wide'({{(WIDE_W-CFG_W){1'b0}}, w_eff_w}) - t_wide'(1);
        w_x0c  = (w_x0 < 0) ? t_wide'(0) : w_x0;
        w_x1c  = (w_x1 > w_wmax) ? w_wmax : w_x1;
    end

    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_row   <= r_span_row;
            r_out_x0    <= w_x0c[SPAN_W-1:0];
            r_out_x1    <= w_x1c[SPAN_W-1:0];
            r_out_empty <= (w_x0c > w_x1c);
            r_out_mask  <= r_mask;
            r_out_last  <= r_span_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_mask, r_out_x1, r_out_x0, r_out_row};
    assign m_axis_tuser  = r_out_empty;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/fcsg_isqrt.sv =====
// ----------------------------------------------------------------------------
// fcsg_isqrt
// Digit-serial floor square root: two radicand bits in, one root bit out
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsg_isqrt import fcsg_pkg::*; #(
    parameter int RB = 14
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [2*RB-1:0] i_radicand,
    output logic                 o_done,
    output logic [RB-1:0]        o_root
);

    localparam int RW = RB + 2;
    localparam int CW = $clog2(RB + 1);

    logic [2*RB-1:0] r_rad;
    logic [RW-1:0]   r_rem;
    logic [RB-1:0]   r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [RW-1:0]   w_shifted;
    logic [RW-1:0]   w_trial;
    logic            w_fit;

    assign w_shifted = {r_rem[RW-3:0], r_rad[2*RB-1 -: 2]};
    assign w_trial   = {r_root, 2'b01};
    assign w_fit     = (w_shifted >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*RB-3:0], 2'b00};
            r_rem  <= w_fit ? (w_shifted - w_trial) : w_shifted;
            r_root <= {r_root[RB-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== rtl/core/fcsg_checker.sv =====
// ----------------------------------------------------------------------------
// fcsg_checker
// Port-level checks of the filled circle span generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsg_checker import fcsg_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [0:0]             s_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]             m_axis_tuser
);

    // a stalled span holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("span changed while stalled");

    // empty flag agrees with the span ends
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser[0] == ($signed(m_axis_tdata[28:12]) > $signed(m_axis_tdata[45:29]))))
        else $error("span_empty disagrees with span ends");

    // left end is clipped at column zero
    a_start_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[28])
        else $error("span_start below zero");

    // a start item makes no span and leaves the input open
    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_START)
            |=> s_axis_tready && !$rose(m_axis_tvalid))
        else $error("start item produced activity");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the filled circle span generator: start and
// next-row items go in, and every span that comes out is checked against a
// span predictor kept inside the bench.
// ----------------------------------------------------------------------------

module tb_top;
    import fcsg_pkg::*;

    localparam int SCREEN_DIM_MAX = 4096;
    localparam int RAD_BITS       = 14;
    localparam int RESET_CYCLES   = 11;
    // time for a next-row item to finish, with a margin on top
    localparam int SETTLE_CYCLES  = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int REPORT_MAX     = 10;

    // one span as the block reports it
    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic signed [SPAN_W-1:0] first_col;
        logic signed [SPAN_W-1:0] last_col;
        logic                     is_empty;
        logic [MASK_W-1:0]        mask;
        logic                     is_last;
    } t_span;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    filled_circle_span_generator #(
        .MAX_SCREEN_DIM (SCREEN_DIM_MAX),
        .RADIUS_BITS    (RAD_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Span predictor state, a copy of what the block should hold
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  width_reg   = 13'd320;
    logic [CFG_W-1:0]  height_reg  = 13'd256;
    longint            circ_cx     = 0;
    longint            circ_cy     = 0;
    longint            circ_r      = 0;
    logic [MASK_W-1:0] circ_mask   = '0;
    longint            cur_row     = 0;
    longint            stop_row    = 0;
    bit                circ_active = 1'b0;

    t_span span_queue[$];       // spans predicted but not yet seen
    int    useful_items = 0;    // starts plus next items that made a span
    int    fault_count  = 0;
    int    cycle_count  = 0;

    // idling percentages, sender side and receiver side
    int tx_idle_pct = 8;
    int rx_idle_pct = 61;

    // long receiver hold-off, requested by toggling hold_req
    bit hold_req  = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------

    // screen registers above the largest screen act as the largest screen
    function automatic longint screen_limit(input logic [CFG_W-1:0] v);
        if (v > SCREEN_DIM_MAX)
            return SCREEN_DIM_MAX;
        return longint'(v);
    endfunction

    // floor square root, built up from the top bit down
    function automatic longint floor_sqrt(input longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = RAD_BITS + 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // one accepted input item: latch a new circle, or work out the span of
    // the current row and queue it
    task automatic advance_circle(input logic cmd, input logic [IN_TDATA_W-1:0] data);
        longint y0, y1, dy, r2, d2, half, x0, x1, wmax;
        t_span  s;
        if (cmd == CMD_START) begin
            circ_cx   = $signed(data[15:0]);
            circ_cy   = $signed(data[31:16]);
            circ_r    = longint'(data[45:32]) & ((longint'(1) << RAD_BITS) - 1);
            circ_mask = data[53:46];
            y0 = circ_cy - circ_r;
            y1 = circ_cy + circ_r;
            if (y0 < 0)
                y0 = 0;
            // height is only looked at here
            if (y1 > screen_limit(height_reg) - 1)
                y1 = screen_limit(height_reg) - 1;
            cur_row     = y0;
            stop_row    = y1;
            circ_active = (y0 <= y1);
            useful_items++;
        end else if (circ_active) begin
            dy = cur_row - circ_cy;
            if (dy < 0)
                dy = -dy;
            r2   = circ_r * circ_r;
            d2   = dy * dy;
            half = floor_sqrt((r2 >= d2) ? r2 - d2 : 0);
            x0   = circ_cx - half;
            x1   = circ_cx + half;
            // width is looked at on every span
            wmax = screen_limit(width_reg) - 1;
            if (x0 < 0)
                x0 = 0;
            if (x1 > wmax)
                x1 = wmax;
            s.row       = cur_row[ROW_W-1:0];
            s.first_col = x0[SPAN_W-1:0];
            s.last_col  = x1[SPAN_W-1:0];
            s.is_empty  = (x0 > x1);
            s.mask      = circ_mask;
            s.is_last   = (cur_row == stop_row);
            span_queue.push_back(s);
            useful_items++;
            if (s.is_last)
                circ_active = 1'b0;
            else
                cur_row++;
        end
        // a next item while idle is dropped by the block
    endtask

    function automatic void log_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    function automatic string span_text(input t_span s);
        return $sformatf("row %0d cols %0d..%0d empty %0b mask %02h last %0b",
                         s.row, s.first_col, s.last_col, s.is_empty, s.mask, s.is_last);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks spans, tracks register writes, predicts on input
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_span got;
        t_span want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.row       = m_axis_tdata[11:0];
                got.first_col = m_axis_tdata[28:12];
                got.last_col  = m_axis_tdata[45:29];
                got.is_empty  = m_axis_tuser[0];
                got.mask      = m_axis_tdata[53:46];
                got.is_last   = m_axis_tlast;
                if (span_queue.size() == 0) begin
                    log_fault({"unexpected span: ", span_text(got)});
                end else begin
                    want = span_queue.pop_front();
                    if (got.row !== want.row || got.first_col !== want.first_col
                        || got.last_col !== want.last_col
                        || got.is_empty !== want.is_empty
                        || got.mask !== want.mask || got.is_last !== want.is_last)
                        log_fault({"span mismatch: expected ", span_text(want),
                                   " / got ", span_text(got)});
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  width_reg  = i_cfg_data;
                    CFG_SCREEN_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_circle(s_axis_tuser[0], s_axis_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // offers one item and returns at the edge that takes it; tvalid stays
    // high so that a following item goes out back to back
    task automatic send_item(input logic cmd, input logic [IN_TDATA_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    function automatic logic [IN_TDATA_W-1:0] pack_circle(input int cx, input int cy,
                                                          input int r, input int mask);
        return {2'b00, mask[7:0], r[13:0], cy[15:0], cx[15:0]};
    endfunction

    task automatic start_circle(input int cx, input int cy, input int r, input int mask);
        send_item(CMD_START, pack_circle(cx, cy, r, mask));
    endtask

    // next-row items carry random, ignored payload
    task automatic next_row();
        send_item(CMD_NEXT, pack_circle($urandom, $urandom, $urandom, $urandom));
    endtask

    // stop offering, wait for every span due, then for the block to go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (span_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // next while idle, then a zero radius circle at the origin
    task automatic test_idle_and_dot();
        next_row();
        start_circle(0, 0, 0, 8'hFF);
        next_row();
        next_row();
        settle();
    endtask

    // far corners with the largest radius, clipping on both sides, and a
    // start that replaces a circle still being drawn
    task automatic test_extremes_and_restart();
        start_circle(-32768, -32768, 16383, 8'h55);
        next_row();
        start_circle(32767, 32767, 16383, 8'h00);
        next_row();
        start_circle(160, 128, 16383, 8'hAA);
        next_row();
        next_row();
        start_circle(5, 3, 2, 8'h81);
        repeat (6) next_row();
        settle();
    endtask

    // zero, oversized and one-pixel screens; width read per span, height
    // only at start
    task automatic test_screen_registers();
        write_reg(CFG_SCREEN_WIDTH, 0);
        write_reg(CFG_SCREEN_HEIGHT, 8191);
        start_circle(10, 10, 1, 8'h0F);
        next_row();
        next_row();
        write_reg(CFG_SCREEN_HEIGHT, 0);
        start_circle(10, 10, 1, 8'hF0);
        next_row();
        write_reg(CFG_SCREEN_WIDTH, 8191);
        write_reg(CFG_SCREEN_HEIGHT, 4096);
        start_circle(4090, 4095, 3, 8'hC3);
        next_row();
        // the circle stays live across these writes
        write_reg(CFG_SCREEN_WIDTH, 1);
        write_reg(CFG_SCREEN_HEIGHT, 1);
        repeat (4) next_row();
        write_reg(CFG_SCREEN_WIDTH, 320);
        write_reg(CFG_SCREEN_HEIGHT, 256);
    endtask

    // receiver holds off while rows keep coming, so the input must stall
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req    <= ~hold_req;
        start_circle(160, 128, 60, 8'h3C);
        repeat (20) next_row();
        settle();
    endtask

    // mostly well-formed circles with random content, some noise items
    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input int w, input int h, input int goal);
        int mark, vis_w, vis_h, r, cx, cy, rows;
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        vis_w = (w > SCREEN_DIM_MAX) ? SCREEN_DIM_MAX : w;
        vis_h = (h > SCREEN_DIM_MAX) ? SCREEN_DIM_MAX : h;
        mark  = useful_items;
        while (useful_items - mark < goal) begin
            if ($urandom_range(99) < 85) begin
                case ($urandom_range(9))
                    0:       r = $urandom_range(16383);
                    1:       r = $urandom_range(200, 13);
                    default: r = $urandom_range(12);
                endcase
                if ($urandom_range(99) < 80) begin
                    cx = $urandom_range(vis_w + 40) - 20;
                    cy = $urandom_range(vis_h + 40) - 20;
                end else begin
                    cx = $urandom;
                    cy = $urandom;
                end
                start_circle(cx, cy, r, $urandom);
                // sometimes cut short by the next start, sometimes one too many
                rows = (2 * r + 2 > 40) ? 40 : 2 * r + 2;
                repeat ($urandom_range(rows, 1)) next_row();
            end else begin
                send_item(1'($urandom_range(1)),
                          pack_circle($urandom, $urandom, $urandom, $urandom));
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_SCREEN_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_START;
        m_axis_tready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_dot();
        test_extremes_and_restart();
        test_screen_registers();
        test_output_stall();
        test_random_traffic(8, 61, 4096, 4096, 130);
        test_random_traffic(61, 8, $urandom_range(400, 1), $urandom_range(400, 1), 130);
        test_random_traffic(0, 0, 320, 256, 130);

        settle();
        if (fault_count == 0 && span_queue.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
